[rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal assembler.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int COORD_W  = 16;
   localparam int NORM_F   = 14;
   localparam int NORM_W   = NORM_F + 2;
   localparam int IDX_W    = 13;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DEGEN   = 2'd1,
      ST_BAD_IDX = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic                       mode;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
      logic [IDX_W-1:0]           corner_index_a;
      logic [IDX_W-1:0]           corner_index_b;
      logic [IDX_W-1:0]           corner_index_c;
   } req_type;

   typedef struct packed {
      logic [1:0]                 corner;
      logic signed [COORD_W-1:0]  vertex_x;
      logic signed [COORD_W-1:0]  vertex_y;
      logic signed [COORD_W-1:0]  vertex_z;
      logic signed [NORM_W-1:0]   normal_x;
      logic signed [NORM_W-1:0]   normal_y;
      logic signed [NORM_W-1:0]   normal_z;
      logic [1:0]                 status;
      logic                       last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_RD_W, S_CROSS, S_SQ, S_SQRT,
      S_DIV, S_EMIT_V, S_EMIT_F, S_EMIT_E
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       rd_en;
      logic [1:0] rd_sel;     // which corner index addresses the store
      logic       cap_en;     // capture read data
      logic [1:0] cap_sel;    // into which corner
      logic       cross_en;
      logic       sq_en;
      logic       sqrt_start;
      logic       sqrt_step;
      logic       div_start;
      logic       div_step;
   } cmd_type;

   typedef struct packed {
      logic       cross_zero;
      logic       sqrt_done;
      logic       div_done;
   } sts_type;

endpackage

[rtl/tfn_ram.sv]
// ----------------------------------------------------------------------------
// tfn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tfn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[rtl/tfn_datapath.sv]
// ----------------------------------------------------------------------------
// tfn_datapath
// Corner registers, cross product, squared length, bit-serial square root
// and a shared restoring divider for the three normal components.
// ----------------------------------------------------------------------------
module tfn_datapath #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                        clock,
   input  tfn_pkg::cmd_type            cmd,
   input  logic [3*COORD_WIDTH-1:0]    rd_data,
   output tfn_pkg::sts_type            sts,
   output logic [3*COORD_WIDTH-1:0]    corner_a,
   output logic [3*COORD_WIDTH-1:0]    corner_b,
   output logic [3*COORD_WIDTH-1:0]    corner_c,
   output logic [3*tfn_pkg::NORM_W-1:0] normal
);
   import tfn_pkg::*;

   localparam int EW = COORD_WIDTH + 1;     // edge width
   localparam int PW = 2 * EW;              // product width
   localparam int CW = PW + 1;              // cross width
   localparam int MW = CW - 1;              // cross magnitude width
   localparam int SW = 2 * MW + 2;          // sum of squares width
   localparam int SWE = SW + (SW % 2);      // even
   localparam int LW = SWE / 2;             // root width
   localparam int NW = MW + NORM_F + 1;     // dividend width
   localparam int QCW = $clog2(NW + 1);
   localparam int RCW = $clog2(LW + 1);

   logic [3*COORD_WIDTH-1:0] ca_ff, cb_ff, cc_ff;
   logic signed [CW-1:0]     cr_ff [3];
   logic [MW-1:0]            mag_ff [3];
   logic [SWE-1:0]           sum_ff;
   logic [SWE-1:0]           rad_ff;
   logic [LW-1:0]            root_ff;
   logic [LW+1:0]            rem_ff;
   logic [RCW-1:0]           rcnt_ff;
   logic [1:0]               dcomp_ff;
   logic [NW-1:0]            dvd_ff;
   logic [NW-1:0]            quo_ff;
   logic [LW:0]              drem_ff;
   logic [QCW-1:0]           dcnt_ff;
   logic [NORM_W-1:0]        nrm_ff [3];
   logic [1:0]               sq_cnt_ff;

   logic signed [COORD_WIDTH-1:0] a [3], b [3], c [3];
   logic signed [EW-1:0] e1 [3], e2 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a[i]  = ca_ff[i*COORD_WIDTH +: COORD_WIDTH];
         b[i]  = cb_ff[i*COORD_WIDTH +: COORD_WIDTH];
         c[i]  = cc_ff[i*COORD_WIDTH +: COORD_WIDTH];
         e1[i] = EW'(a[i]) - EW'(b[i]);
         e2[i] = EW'(a[i]) - EW'(c[i]);
      end
   end

   // Component order is x,y,z at index 2,1,0 of the packed corner word.
   // Packed as {x,y,z}: index 2 = x, 1 = y, 0 = z.
   logic signed [PW-1:0] p [6];
   always_comb begin
      p[0] = e1[1] * e2[0];   // y1*z2
      p[1] = e2[1] * e1[0];   // y2*z1
      p[2] = e2[2] * e1[0];   // x2*z1
      p[3] = e1[2] * e2[0];   // x1*z2
      p[4] = e1[2] * e2[1];   // x1*y2
      p[5] = e2[2] * e1[1];   // x2*y1
   end

   // Square and sum, one component a cycle.
   logic [2*MW-1:0] sq_in;
   assign sq_in = mag_ff[sq_cnt_ff] * mag_ff[sq_cnt_ff];

   // Square root step.
   logic [LW+1:0] trial;
   logic [LW+1:0] cur;
   assign cur   = {rem_ff[LW-1:0], rad_ff[SWE-1 -: 2]};
   assign trial = cur - {root_ff, 2'b01};

   // Divider step.
   logic [LW:0] dshift;
   assign dshift = {drem_ff[LW-1:0], dvd_ff[NW-1]};

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         case (cmd.cap_sel)
            2'd0:    ca_ff <= rd_data;
            2'd1:    cb_ff <= rd_data;
            default: cc_ff <= rd_data;
         endcase
      end
      if (cmd.cross_en) begin
         cr_ff[0] <= CW'(p[4]) - CW'(p[5]); // z
         cr_ff[1] <= CW'(p[2]) - CW'(p[3]); // y
         cr_ff[2] <= CW'(p[0]) - CW'(p[1]); // x
         sq_cnt_ff <= 2'd0;
         sum_ff    <= '0;
      end
      if (cmd.sq_en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= cr_ff[i][CW-1] ? MW'(-cr_ff[i]) : MW'(cr_ff[i]);
         end
         if (cmd.sqrt_start == 1'b0 && sq_cnt_ff != 2'd3) begin
         end
      end
      if (cmd.sqrt_step && rcnt_ff == '0 && !cmd.sqrt_start) begin
      end
      // Sum accumulation runs while sq_cnt counts 0..2 after magnitudes load.
      if (cmd.sq_en == 1'b0 && sq_cnt_ff != 2'd3 && !cmd.cross_en
          && cmd.sqrt_start == 1'b0 && cmd.sqrt_step == 1'b0
          && cmd.div_start == 1'b0 && cmd.div_step == 1'b0 && !cmd.cap_en
          && !cmd.rd_en) begin
         sum_ff    <= sum_ff + SWE'(sq_in);
         sq_cnt_ff <= sq_cnt_ff + 2'd1;
      end
      if (cmd.sqrt_start) begin
         rad_ff  <= sum_ff;
         root_ff <= '0;
         rem_ff  <= '0;
         rcnt_ff <= RCW'(LW);
      end else if (cmd.sqrt_step && rcnt_ff != '0) begin
         rad_ff <= {rad_ff[SWE-3:0], 2'b00};
         if (!trial[LW+1]) begin
            rem_ff  <= trial;
            root_ff <= {root_ff[LW-2:0], 1'b1};
         end else begin
            rem_ff  <= cur;
            root_ff <= {root_ff[LW-2:0], 1'b0};
         end
         rcnt_ff <= rcnt_ff - RCW'(1);
      end
      if (cmd.div_start) begin
         dcomp_ff <= 2'd0;
         dvd_ff   <= (NW'(mag_ff[0]) << NORM_F) + NW'(root_ff >> 1);
         drem_ff  <= '0;
         quo_ff   <= '0;
         dcnt_ff  <= QCW'(NW);
      end else if (cmd.div_step) begin
         if (dcnt_ff != '0) begin
            dvd_ff <= {dvd_ff[NW-2:0], 1'b0};
            if (dshift >= {1'b0, root_ff}) begin
               drem_ff <= dshift - {1'b0, root_ff};
               quo_ff  <= {quo_ff[NW-2:0], 1'b1};
            end else begin
               drem_ff <= dshift;
               quo_ff  <= {quo_ff[NW-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - QCW'(1);
         end else begin
            // Finish this component: clamp, sign and move to the next, or mark the division done after the last.
            if (quo_ff > NW'(1 << NORM_F)) begin
               nrm_ff[dcomp_ff] <= cr_ff[dcomp_ff][CW-1] ?
                  NORM_W'(-(1 << NORM_F)) : NORM_W'(1 << NORM_F);
            end else begin
               nrm_ff[dcomp_ff] <= cr_ff[dcomp_ff][CW-1] ?
                  NORM_W'(-quo_ff) : NORM_W'(quo_ff);
            end
            if (dcomp_ff != 2'd2) begin
               dcomp_ff <= dcomp_ff + 2'd1;
               dvd_ff   <= (NW'(mag_ff[dcomp_ff + 2'd1]) << NORM_F)
                           + NW'(root_ff >> 1);
               drem_ff  <= '0;
               quo_ff   <= '0;
               dcnt_ff  <= QCW'(NW);
            end else begin
               dcomp_ff <= 2'd3;
            end
         end
      end
   end

   assign sts.cross_zero = (cr_ff[0] == '0) && (cr_ff[1] == '0) && (cr_ff[2] == '0);
   assign sts.sqrt_done  = (rcnt_ff == '0) && (sq_cnt_ff == 2'd3);
   assign sts.div_done   = (dcomp_ff == 2'd3);

   assign corner_a = ca_ff;
   assign corner_b = cb_ff;
   assign corner_c = cc_ff;
   assign normal   = {nrm_ff[2], nrm_ff[1], nrm_ff[0]};
endmodule

[rtl/tfn_ctrl.sv]
// ----------------------------------------------------------------------------
// tfn_ctrl
// Sequencer for face items: store reads, cross product, root, divisions.
// ----------------------------------------------------------------------------
module tfn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tfn_pkg::sts_type     sts,
   output tfn_pkg::cmd_type     cmd,
   output logic                 done,
   output logic                 degen
);
   import tfn_pkg::*;

   state_type state_ff, state_in;
   logic      degen_ff, degen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         degen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         degen_ff <= degen_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      degen_in = degen_ff;
      cmd      = '0;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = 2'd0;
               state_in   = S_RD_A;
            end
         end
         S_RD_A: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd1;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd0;
            state_in    = S_RD_B;
         end
         S_RD_B: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd2;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd1;
            state_in    = S_RD_C;
         end
         S_RD_C: begin
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd2;
            state_in    = S_CROSS;
         end
         S_CROSS: begin
            cmd.cross_en = 1'b1;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.sq_en = 1'b1;
            degen_in  = sts.cross_zero;
            state_in  = sts.cross_zero ? S_EMIT_F : S_RD_W;
         end
         S_RD_W: begin
            // The sum of squares of the three components accumulates here.
            if (sts.sqrt_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) begin
               cmd.sqrt_step = 1'b0;
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.div_step = 1'b0;
               state_in     = S_EMIT_F;
            end
         end
         S_EMIT_F: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign degen = degen_ff;
endmodule

[rtl/triangle_face_normal_assembler_top.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_assembler_top
// Vertex store plus face normal engine with a three-result output stage.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel (valid/stall). A vertex item is
// appended to the vertex store and answered by one transfer on rsp_ echoing
// its coordinates (status full when the store has no room). A face item
// names three 1-based vertices; bad numbers give one bad-index transfer.
// Otherwise the three corners are read from the store RAM one per cycle,
// the cross product is formed, its squared length is accumulated, a
// bit-serial square root runs one result bit per cycle and a shared
// restoring divider produces the three normal components one quotient
// bit per cycle. The face is then answered by three output transfers.
// The block works on one item at a time; req_stall stays high while an item
// is in flight or its results wait. A stalled rsp_ transfer holds its
// payload. Reset empties the store (count to zero) and returns to idle.
// ----------------------------------------------------------------------------
module triangle_face_normal_assembler_top #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tfn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tfn_pkg::rsp_type  rsp_data
);
   import tfn_pkg::*;

   localparam int AW = $clog2(VERTEX_DEPTH);
   localparam int CNTW = $clog2(VERTEX_DEPTH + 1);
   localparam int VW = 3 * COORD_W;

   typedef enum logic [1:0] {T_IDLE, T_FACE, T_OUT} top_state_type;

   top_state_type        tstate_ff;
   logic [CNTW-1:0]      count_ff;
   req_type              req_ff;
   logic [1:0]           ocnt_ff;    // corner being emitted
   logic                 multi_ff;   // three results pending
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic                 accept;
   logic                 bad_idx;
   cmd_type              cmd;
   sts_type              sts;
   logic                 eng_done, eng_degen;
   logic [VW-1:0]        rd_data, ca, cb, cc;
   logic [3*NORM_W-1:0]  nrm;
   logic [AW-1:0]        rd_addr;
   logic [IDX_W-1:0]     sel_idx;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (tstate_ff != T_IDLE) || rsp_valid_ff;

   function automatic logic idx_bad(input logic [IDX_W-1:0] i,
                                    input logic [CNTW-1:0] n);
      idx_bad = (i == '0) || (CNTW'(i) > n) ||
                ((IDX_W > CNTW) && ((i >> CNTW) != '0));
   endfunction

   assign bad_idx = idx_bad(req_data.corner_index_a, count_ff) ||
                    idx_bad(req_data.corner_index_b, count_ff) ||
                    idx_bad(req_data.corner_index_c, count_ff);

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    sel_idx = req_ff.corner_index_a;
         2'd1:    sel_idx = req_ff.corner_index_b;
         default: sel_idx = req_ff.corner_index_c;
      endcase
   end
   // For idx the stored slot is idx-1; accept-time read uses req_data.
   assign rd_addr = (tstate_ff == T_IDLE) ? AW'(req_data.corner_index_a - 1'b1)
                                          : AW'(sel_idx - 1'b1);

   tfn_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (accept && !req_data.mode && (count_ff < CNTW'(VERTEX_DEPTH))),
      .wr_addr (AW'(count_ff)),
      .wr_data ({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tfn_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (accept && req_data.mode && !bad_idx),
      .sts   (sts),
      .cmd   (cmd),
      .done  (eng_done),
      .degen (eng_degen)
   );

   tfn_datapath #(.COORD_WIDTH(COORD_W)) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .rd_data  (rd_data),
      .sts      (sts),
      .corner_a (ca),
      .corner_b (cb),
      .corner_c (cc),
      .normal   (nrm)
   );

   // Result for one corner of the current face.
   function automatic rsp_type face_rsp(input logic [1:0] k, input logic [VW-1:0] v,
                                        input logic dg, input logic [3*NORM_W-1:0] n);
      rsp_type r;
      r.corner   = k;
      r.vertex_x = v[2*COORD_W +: COORD_W];
      r.vertex_y = v[COORD_W +: COORD_W];
      r.vertex_z = v[0 +: COORD_W];
      r.normal_x = dg ? '0 : n[2*NORM_W +: NORM_W];
      r.normal_y = dg ? '0 : n[NORM_W +: NORM_W];
      r.normal_z = dg ? '0 : n[0 +: NORM_W];
      r.status   = dg ? ST_DEGEN : ST_OK;
      r.last     = (k == 2'd2);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         tstate_ff    <= T_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ocnt_ff      <= '0;
         multi_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            if (multi_ff && ocnt_ff != 2'd2) begin
               ocnt_ff <= ocnt_ff + 2'd1;
               rsp_ff  <= face_rsp(ocnt_ff + 2'd1, (ocnt_ff == 2'd0) ? cb : cc,
                                   eng_degen, nrm);
            end else begin
               rsp_valid_ff <= 1'b0;
               multi_ff     <= 1'b0;
               tstate_ff    <= T_IDLE;
            end
         end
         if (accept) begin
            req_ff <= req_data;
            if (!req_data.mode) begin
               rsp_valid_ff    <= 1'b1;
               rsp_ff          <= '0;
               rsp_ff.vertex_x <= req_data.coord_x;
               rsp_ff.vertex_y <= req_data.coord_y;
               rsp_ff.vertex_z <= req_data.coord_z;
               rsp_ff.last     <= 1'b1;
               if (count_ff < CNTW'(VERTEX_DEPTH)) begin
                  count_ff      <= count_ff + CNTW'(1);
                  rsp_ff.status <= ST_OK;
               end else begin
                  rsp_ff.status <= ST_FULL;
               end
            end else if (bad_idx) begin
               rsp_valid_ff  <= 1'b1;
               rsp_ff        <= '0;
               rsp_ff.status <= ST_BAD_IDX;
               rsp_ff.last   <= 1'b1;
            end else begin
               tstate_ff <= T_FACE;
            end
         end
         if (tstate_ff == T_FACE && eng_done) begin
            tstate_ff    <= T_OUT;
            rsp_valid_ff <= 1'b1;
            multi_ff     <= 1'b1;
            ocnt_ff      <= 2'd0;
            rsp_ff       <= face_rsp(2'd0, ca, eng_degen, nrm);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[test/triangle_face_normal_assembler_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_assembler_checker
// Watches both channels, predicts every result transfer and compares it.
// ----------------------------------------------------------------------------
module triangle_face_normal_assembler_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  tfn_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tfn_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import tfn_pkg::*;

   localparam int DEPTH = 4096;

   logic signed [COORD_W-1:0] store_x [DEPTH];
   logic signed [COORD_W-1:0] store_y [DEPTH];
   logic signed [COORD_W-1:0] store_z [DEPTH];
   int                        vertex_total;
   rsp_type                   expected_q [$];

   initial begin
      fail_count = 0;
      vertex_total = 0;
   end

   assign pending = expected_q.size();

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Unit normal of the face; returns 1 when the cross product is zero.
   function automatic bit face_normal(input longint p [3][3], output longint n [3]);
      longint          e [6];
      longint          cr [3];
      longint unsigned m [3];
      longint unsigned mx, sum, len, q;
      int              s;
      for (int i = 0; i < 3; i++) begin
         e[i] = p[0][i] - p[1][i];
         e[3+i] = p[0][i] - p[2][i];
         n[i] = 0;
      end
      // Edges of 16-bit coordinates never reach 2^30, so no edge scaling.
      cr[0] = e[1] * e[5] - e[4] * e[2];
      cr[1] = e[3] * e[2] - e[0] * e[5];
      cr[2] = e[0] * e[4] - e[3] * e[1];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag(cr[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 1;
      s = 0;
      while ((mx >> s) >= 64'h8000_0000) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] >>= s;
         sum += m[i] * m[i];
      end
      len = root_floor(sum);
      if (len == 0) return 1;
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << NORM_F) + (len >> 1)) / len;
         if (q > (64'd1 << NORM_F)) q = 64'd1 << NORM_F;
         n[i] = (cr[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 0;
   endfunction

   task automatic predict_results(input req_type it);
      rsp_type r;
      int      idx [3];
      longint  p [3][3];
      longint  n [3];
      bit      degen;
      r = '0;
      r.last = 1'b1;
      if (it.mode == 1'b0) begin
         r.vertex_x = it.coord_x;
         r.vertex_y = it.coord_y;
         r.vertex_z = it.coord_z;
         if (vertex_total < DEPTH) begin
            store_x[vertex_total] = it.coord_x;
            store_y[vertex_total] = it.coord_y;
            store_z[vertex_total] = it.coord_z;
            vertex_total++;
            r.status = ST_OK;
         end else begin
            r.status = ST_FULL;
         end
         expected_q.push_back(r);
         return;
      end
      idx[0] = it.corner_index_a;
      idx[1] = it.corner_index_b;
      idx[2] = it.corner_index_c;
      for (int k = 0; k < 3; k++) begin
         if (idx[k] == 0 || idx[k] > vertex_total) begin
            r.status = ST_BAD_IDX;
            expected_q.push_back(r);
            return;
         end
      end
      for (int k = 0; k < 3; k++) begin
         p[k][0] = store_x[idx[k]-1];
         p[k][1] = store_y[idx[k]-1];
         p[k][2] = store_z[idx[k]-1];
      end
      degen = face_normal(p, n);
      for (int k = 0; k < 3; k++) begin
         r.corner = 2'(k);
         r.vertex_x = COORD_W'(p[k][0]);
         r.vertex_y = COORD_W'(p[k][1]);
         r.vertex_z = COORD_W'(p[k][2]);
         r.normal_x = degen ? '0 : NORM_W'(n[0]);
         r.normal_y = degen ? '0 : NORM_W'(n[1]);
         r.normal_z = degen ? '0 : NORM_W'(n[2]);
         r.status = degen ? ST_DEGEN : ST_OK;
         r.last = (k == 2);
         expected_q.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_results(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               rsp_type w;
               w = expected_q.pop_front();
               check_field("corner", w.corner, rsp_data.corner);
               check_field("vertex_x", w.vertex_x, rsp_data.vertex_x);
               check_field("vertex_y", w.vertex_y, rsp_data.vertex_y);
               check_field("vertex_z", w.vertex_z, rsp_data.vertex_z);
               check_field("normal_x", w.normal_x, rsp_data.normal_x);
               check_field("normal_y", w.normal_y, rsp_data.normal_y);
               check_field("normal_z", w.normal_z, rsp_data.normal_z);
               check_field("status", w.status, rsp_data.status);
               check_field("last", w.last, rsp_data.last);
            end
         end
      end
   end

endmodule

[test/triangle_face_normal_assembler_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_assembler_top_test
// Directed and random vertex and face items against a self-checking monitor.
// ----------------------------------------------------------------------------
module triangle_face_normal_assembler_top_test;
   import tfn_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   // Vertices sent so far; used to aim face indices at stored entries.
   int      sent_vertices = 0;
   // When set, neither side inserts idle cycles.
   bit      steady = 1'b0;
   // Set by the sender to ask the receiver for one long hold-off.
   bit      long_hold = 1'b0;

   always #2 clock = ~clock;

   triangle_face_normal_assembler_top DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   triangle_face_normal_assembler_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending
   );

   // Offer one item and hold it until the block takes it. Valid is left high
   // afterwards unless a random gap follows, so back-to-back transfers occur.
   task automatic send_item(input req_type it);
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!it.mode && sent_vertices < 4096) sent_vertices++;
      @(negedge clock);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom});
      it.mode = 1'b0;
      it.coord_x = x;
      it.coord_y = y;
      it.coord_z = z;
      send_item(it);
   endtask

   task automatic send_face(input int a, input int b, input int c);
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom});
      it.mode = 1'b1;
      it.corner_index_a = IDX_W'(a);
      it.corner_index_b = IDX_W'(b);
      it.corner_index_c = IDX_W'(c);
      send_item(it);
   endtask

   // Mostly a stored vertex; now and then zero, one past the count or noise.
   function automatic int pick_index();
      int r;
      r = $urandom_range(0, 19);
      if (sent_vertices == 0 || r == 0) return 0;
      if (r == 1) return sent_vertices + 1;
      if (r == 2) return $urandom_range(0, 8191);
      return $urandom_range(1, sent_vertices);
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 2047)) - 16'd1024;
         1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A face before any vertex exists has only bad indices.
      send_face(1, 1, 1);
      send_vertex(16'h7FFF, 16'h8000, 16'h0000);
      send_vertex(16'h8000, 16'h7FFF, 16'h7FFF);
      send_vertex(16'h0000, 16'h0000, 16'h8000);
      send_vertex(16'h0100, 16'h0000, 16'h0000);
      send_vertex(16'h0000, 16'h0100, 16'h0000);
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      send_vertex(16'h0200, 16'h0200, 16'h0000);
      send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF);
      // Extreme corners push the cross product past 31 bits.
      send_face(1, 2, 3);
      send_face(6, 4, 5);
      // A repeated corner gives a zero cross product; the next face lies in z = 0.
      send_face(4, 4, 5);
      send_face(6, 4, 7);
      // Zero in each position, then out-of-range numbers.
      send_face(0, 1, 2);
      send_face(1, 0, 2);
      send_face(1, 2, 0);
      send_face(9, 1, 2);
      send_face(1, 2, 8191);
      send_face(8, 6, 4);
      send_face(3, 2, 1);

      for (int n = 0; n < 160; n++) begin
         if (n == 40) long_hold = 1'b1;
         if (n == 90) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         if ($urandom_range(0, 9) < 4) begin
            send_vertex(pick_coord(), pick_coord(), pick_coord());
         end else if ($urandom_range(0, 9) == 0 && sent_vertices > 0) begin
            int a;
            a = $urandom_range(1, sent_vertices);
            send_face(a, a, pick_index());
         end else begin
            send_face(pick_index(), pick_index(), pick_index());
         end
      end

      // Last part: no idling. Fill the store, overflow it, then use the top
      // entry and one number beyond it.
      steady = 1'b1;
      while (sent_vertices < 4096)
         send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
      send_vertex(16'h1234, 16'h8000, 16'h7FFF);
      send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
      send_face(4096, 1, 2);
      send_face(4095, 4096, 4094);
      send_face(4097, 1, 2);
      for (int n = 0; n < 10; n++)
         send_face(pick_index(), pick_index(), pick_index());
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("triangle_face_normal_assembler_top test passed");
      else
         $display("triangle_face_normal_assembler_top test failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("triangle_face_normal_assembler_top test failed");
      $finish;
   end

endmodule
